// ===== rtl/core/byte_pair_dictionary_encoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// byte pair dictionary encoder assertion macros
// shared property forms for the checker, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BYTE_PAIR_DICTIONARY_ENCODER_CORE_DEFINES_SVH
`define BYTE_PAIR_DICTIONARY_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define BPDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bpde_pkg.sv =====
// ----------------------------------------------------------------------------
// bpde_pkg
// constants, codes and shared types of the byte pair dictionary encoder
// ----------------------------------------------------------------------------
package bpde_pkg;

    // storage sizes
    localparam int MAX_BYTES = 4096;
    localparam int MAX_DICT  = 255;
    localparam int BYTE_AW   = $clog2(MAX_BYTES);
    localparam int LEN_W     = 13;
    localparam int CNT_W     = 13;
    localparam int PAIR_AW   = 16;
    localparam int DICT_AW   = 8;
    localparam int DICT_W    = 24;
    localparam int FREE_W    = 9;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAIR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRY = 2'd2;
    localparam logic [12:0] RST_MIN_PAIR  = 13'd4;
    localparam logic [12:0] RST_MIN_LEN   = 13'd10;
    localparam logic [7:0]  RST_MAX_ENTRY = 8'd255;

    // item codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_READ    = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [2:0] ST_APPLIED   = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_NO_FREE   = 3'd2;
    localparam logic [2:0] ST_NO_PAIR   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // token scanner control and status
    typedef struct packed {
        logic       clear;
        logic       mark;
        logic [7:0] mark_value;
        logic       seek;
        logic [7:0] seek_from;
    } tok_ctl_t;

    typedef struct packed {
        logic              found;
        logic [7:0]        token;
        logic [FREE_W-1:0] free_count;
    } tok_st_t;

endpackage

// ===== rtl/core/bpde_if.sv =====
// ----------------------------------------------------------------------------
// bpde channel interfaces
// request, response and configuration channels with valid/ready handshakes
// ----------------------------------------------------------------------------
interface bpde_req_if
    import bpde_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, command, data_byte, is_last, input ready);
    modport sink   (input valid, command, data_byte, is_last, output ready);
endinterface

interface bpde_rsp_if
    import bpde_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [2:0]       status;
    logic [LEN_W-1:0] block_length;
    logic [7:0]       entry_count;
    logic [7:0]       out_byte;
    logic             out_last;

    modport source (output valid, kind, status, block_length, entry_count, out_byte,
                    out_last, input ready);
    modport sink   (input valid, kind, status, block_length, entry_count, out_byte,
                    out_last, output ready);
endinterface

interface bpde_cfg_if
    import bpde_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/byte_pair_dictionary_encoder_core.sv =====
// ----------------------------------------------------------------------------
// byte_pair_dictionary_encoder_core
// byte pair encoder: load bytes, encode on the last one, read the block back
// ----------------------------------------------------------------------------
// Usage:
//   request carries load items (command 0, data_byte, is_last) and read items
//   (command 1). response carries one status item per encode and one item per
//   read. cfg writes min_pair_count, min_input_length and max_entries; it is
//   always ready; it is to be written only while the block is idle, which the
//   block itself does not enforce. After reset a clearing pass zeroes all 65536
//   pair count entries with request.ready low.
//   Loads are taken back to back; a read passes S_RD_ADDR and S_RD_DATA before
//   its item is registered. The last load starts the encode, a sequencer over
//   one pair count memory: copy the loaded bytes, then per dictionary entry
//   count the pairs (S_CNT_*), find the max (S_SCN_*), seek a free token and
//   substitute (S_SUB_*); the status item follows.
//   request.ready is low while an item waits on response; a stalled receiver
//   holds the block but loses nothing.
// ----------------------------------------------------------------------------
module byte_pair_dictionary_encoder_core
    import bpde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bpde_req_if.sink   request,
    bpde_rsp_if.source response,
    bpde_cfg_if.sink   cfg
);

    typedef enum logic [20:0] {
        S_CLEAR     = 21'h000001,
        S_IDLE      = 21'h000002,
        S_RD_ADDR   = 21'h000004,
        S_RD_DATA   = 21'h000008,
        S_ENC       = 21'h000010,
        S_CP_RD     = 21'h000020,
        S_CP_WR     = 21'h000040,
        S_CHECK     = 21'h000080,
        S_LOOP      = 21'h000100,
        S_CNT_RD    = 21'h000200,
        S_CNT_KEY   = 21'h000400,
        S_CNT_WR    = 21'h000800,
        S_SCN_RD    = 21'h001000,
        S_SCN_KEY   = 21'h002000,
        S_SCN_CMP   = 21'h004000,
        S_DECIDE    = 21'h008000,
        S_SEEK      = 21'h010000,
        S_SUB_RD    = 21'h020000,
        S_SUB_DATA  = 21'h040000,
        S_SUB_FLUSH = 21'h080000,
        S_FINISH    = 21'h100000
    } state_t;

    typedef enum logic [1:0] {
        RS_COUNT,
        RS_DICT,
        RS_WORK,
        RS_END
    } rd_src_t;

    state_t               state_reg, state_next;
    rd_src_t              src_reg, src_next;
    logic [PAIR_AW-1:0]   clr_reg, clr_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic [LEN_W-1:0]     dst_reg, dst_next;
    logic [7:0]           prev_reg, prev_next;
    logic [PAIR_AW-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]     best_cnt_reg, best_cnt_next;
    logic [PAIR_AW-1:0]   best_key_reg, best_key_next;
    logic [7:0]           pend_reg, pend_next;
    logic                 pend_v_reg, pend_v_next;
    logic [7:0]           tok_reg, tok_next;
    logic [7:0]           from_reg, from_next;
    logic [7:0]           entry_reg, entry_next;
    logic [7:0]           limit_reg, limit_next;
    logic [LEN_W-1:0]     stored_reg, stored_next;
    logic [LEN_W-1:0]     wlen_reg, wlen_next;
    logic [LEN_W-1:0]     blen_reg, blen_next;
    logic [LEN_W-1:0]     base_reg, base_next;
    logic [2:0]           status_reg, status_next;
    logic [LEN_W-1:0]     rp_reg, rp_next;
    logic [1:0]           sub_reg, sub_next;
    logic [DICT_AW-1:0]   didx_reg, didx_next;
    logic                 open_reg, open_next;
    logic                 ovf_reg, ovf_next;
    logic [12:0]          min_pair_reg, min_pair_next;
    logic [12:0]          min_len_reg, min_len_next;
    logic [7:0]           max_ent_reg, max_ent_next;
    logic                 ovalid_reg, ovalid_next;
    logic                 okind_reg, okind_next;
    logic [2:0]           ostatus_reg, ostatus_next;
    logic [LEN_W-1:0]     oblen_reg, oblen_next;
    logic [7:0]           oentry_reg, oentry_next;
    logic [7:0]           obyte_reg, obyte_next;
    logic                 olast_reg, olast_next;

    logic                 byte_we;
    logic [BYTE_AW-1:0]   byte_waddr, byte_raddr;
    logic [7:0]           byte_wdata, byte_rdata;
    logic                 work_we;
    logic [BYTE_AW-1:0]   work_waddr, work_raddr;
    logic [7:0]           work_wdata, work_rdata;
    logic                 pair_we;
    logic [PAIR_AW-1:0]   pair_waddr, pair_raddr;
    logic [CNT_W-1:0]     pair_wdata, pair_rdata;
    logic                 dict_we;
    logic [DICT_AW-1:0]   dict_waddr, dict_raddr;
    logic [DICT_W-1:0]    dict_wdata, dict_rdata;

    tok_ctl_t             tok_ctl;
    tok_st_t              tok_st;

    logic                 in_fire;
    logic [LEN_W-1:0]     eff_len;
    logic [CNT_W-1:0]     thr;
    logic [LEN_W-1:0]     base_calc;
    logic [7:0]           lim_calc;
    logic [LEN_W-1:0]     wlen_fin;

    // memories
    bpde_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_byte_ram (
        .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
        .raddr(byte_raddr), .rdata(byte_rdata)
    );

    bpde_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_work_ram (
        .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    bpde_ram #(.WIDTH(CNT_W), .DEPTH(2 ** PAIR_AW)) u_pair_ram (
        .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
        .raddr(pair_raddr), .rdata(pair_rdata)
    );

    bpde_ram #(.WIDTH(DICT_W), .DEPTH(MAX_DICT)) u_dict_ram (
        .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(dict_wdata),
        .raddr(dict_raddr), .rdata(dict_rdata)
    );

    bpde_token_scan u_tok (
        .clk(clk), .rst_n(rst_n), .ctl(tok_ctl), .st(tok_st)
    );

    // handshakes
    assign request.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_fire       = request.valid && request.ready;
    assign cfg.ready     = 1'b1;

    // derived values
    assign eff_len   = open_reg ? stored_reg : '0;
    assign thr       = (min_pair_reg == '0) ? CNT_W'(1) : min_pair_reg;
    assign base_calc = LEN_W'({entry_reg, 1'b0}) + LEN_W'(entry_reg) + LEN_W'(1);
    assign wlen_fin  = dst_reg + LEN_W'(pend_v_reg);

    always_comb
    begin
        lim_calc = max_ent_reg;
        if (tok_st.free_count < {1'b0, lim_calc})
        begin
            lim_calc = tok_st.free_count[7:0];
        end
        if (FREE_W'(MAX_DICT) < {1'b0, lim_calc})
        begin
            lim_calc = 8'(MAX_DICT);
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        src_next      = src_reg;
        clr_next      = clr_reg;
        idx_next      = idx_reg;
        dst_next      = dst_reg;
        prev_next     = prev_reg;
        key_next      = key_reg;
        best_cnt_next = best_cnt_reg;
        best_key_next = best_key_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        tok_next      = tok_reg;
        from_next     = from_reg;
        entry_next    = entry_reg;
        limit_next    = limit_reg;
        stored_next   = stored_reg;
        wlen_next     = wlen_reg;
        blen_next     = blen_reg;
        base_next     = base_reg;
        status_next   = status_reg;
        rp_next       = rp_reg;
        sub_next      = sub_reg;
        didx_next     = didx_reg;
        open_next     = open_reg;
        ovf_next      = ovf_reg;
        min_pair_next = min_pair_reg;
        min_len_next  = min_len_reg;
        max_ent_next  = max_ent_reg;
        ovalid_next   = ovalid_reg;
        okind_next    = okind_reg;
        ostatus_next  = ostatus_reg;
        oblen_next    = oblen_reg;
        oentry_next   = oentry_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;

        byte_we    = 1'b0;
        byte_waddr = eff_len[BYTE_AW-1:0];
        byte_wdata = request.data_byte;
        byte_raddr = idx_reg[BYTE_AW-1:0];
        work_we    = 1'b0;
        work_waddr = dst_reg[BYTE_AW-1:0];
        work_wdata = pend_reg;
        work_raddr = idx_reg[BYTE_AW-1:0];
        pair_we    = 1'b0;
        pair_waddr = key_reg;
        pair_wdata = '0;
        pair_raddr = {prev_reg, work_rdata};
        dict_we    = 1'b0;
        dict_waddr = entry_reg;
        dict_wdata = {tok_st.token, best_key_reg};
        dict_raddr = didx_reg;
        tok_ctl    = '0;

        // configuration writes
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MIN_PAIR:  min_pair_next = cfg.data;
                CFG_MIN_LEN:   min_len_next  = cfg.data;
                CFG_MAX_ENTRY: max_ent_next  = cfg.data[7:0];
                default:       ;
            endcase
        end

        // response taken
        if (ovalid_reg && response.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            // zero the pair counts once after reset
            S_CLEAR:
            begin
                pair_we    = 1'b1;
                pair_waddr = clr_reg;
                clr_next   = clr_reg + PAIR_AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            // accept loads and reads
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (request.command == CMD_LOAD)
                    begin
                        if (!open_reg)
                        begin
                            tok_ctl.clear = 1'b1;
                            ovf_next      = 1'b0;
                        end
                        if (eff_len < LEN_W'(MAX_BYTES))
                        begin
                            byte_we            = 1'b1;
                            stored_next        = eff_len + LEN_W'(1);
                            tok_ctl.mark       = 1'b1;
                            tok_ctl.mark_value = request.data_byte;
                        end
                        else
                        begin
                            stored_next = eff_len;
                            ovf_next    = 1'b1;
                        end
                        open_next = !request.is_last;
                        if (request.is_last)
                        begin
                            state_next = S_ENC;
                        end
                    end
                    else
                    begin
                        state_next = S_RD_ADDR;
                    end
                end
            end

            // read: pick the source of the next block byte
            S_RD_ADDR:
            begin
                work_raddr = BYTE_AW'(rp_reg - base_reg);
                if (rp_reg >= blen_reg)
                begin
                    src_next = RS_END;
                end
                else if (rp_reg == '0 && base_reg != '0)
                begin
                    src_next = RS_COUNT;
                end
                else if (rp_reg < base_reg)
                begin
                    src_next = RS_DICT;
                end
                else
                begin
                    src_next = RS_WORK;
                end
                state_next = S_RD_DATA;
            end

            // read: form the item and advance the pointer
            S_RD_DATA:
            begin
                ovalid_next  = 1'b1;
                okind_next   = KIND_READ;
                ostatus_next = status_reg;
                oblen_next   = blen_reg;
                oentry_next  = entry_reg;
                olast_next   = ({1'b0, rp_reg} + (LEN_W+1)'(1)) >= {1'b0, blen_reg};
                case (src_reg)
                    RS_COUNT: obyte_next = entry_reg;
                    RS_DICT:
                    begin
                        case (sub_reg)
                            2'd0:    obyte_next = dict_rdata[23:16];
                            2'd1:    obyte_next = dict_rdata[15:8];
                            default: obyte_next = dict_rdata[7:0];
                        endcase
                    end
                    RS_WORK:  obyte_next = work_rdata;
                    default:
                    begin
                        obyte_next = '0;
                        olast_next = 1'b1;
                    end
                endcase
                if (src_reg != RS_END)
                begin
                    rp_next = rp_reg + LEN_W'(1);
                    if (rp_reg != '0)
                    begin
                        if (sub_reg == 2'd2)
                        begin
                            sub_next  = 2'd0;
                            didx_next = didx_reg + DICT_AW'(1);
                        end
                        else
                        begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                end
                state_next = S_IDLE;
            end

            // encode start: reset the read side, copy loaded bytes
            S_ENC:
            begin
                rp_next    = '0;
                sub_next   = '0;
                didx_next  = '0;
                idx_next   = '0;
                state_next = S_CP_RD;
            end

            S_CP_RD:
            begin
                state_next = S_CP_WR;
            end

            S_CP_WR:
            begin
                work_we    = 1'b1;
                work_waddr = idx_reg[BYTE_AW-1:0];
                work_wdata = byte_rdata;
                idx_next   = idx_reg + LEN_W'(1);
                state_next = ((idx_reg + LEN_W'(1)) < stored_reg) ? S_CP_RD : S_CHECK;
            end

            // early exits and entry limit
            S_CHECK:
            begin
                wlen_next  = stored_reg;
                entry_next = '0;
                from_next  = '0;
                limit_next = lim_calc;
                state_next = S_FINISH;
                if (ovf_reg)
                begin
                    status_next = ST_OVERFLOW;
                end
                else if (stored_reg < min_len_reg)
                begin
                    status_next = ST_TOO_SHORT;
                end
                else if (tok_st.free_count == '0)
                begin
                    status_next = ST_NO_FREE;
                end
                else
                begin
                    status_next = ST_NO_PAIR;
                    state_next  = S_LOOP;
                end
            end

            S_LOOP:
            begin
                idx_next      = '0;
                best_cnt_next = '0;
                best_key_next = '0;
                state_next    = (entry_reg < limit_reg) ? S_CNT_RD : S_FINISH;
            end

            // count every adjacent pair
            S_CNT_RD:
            begin
                state_next = S_CNT_KEY;
            end

            S_CNT_KEY:
            begin
                prev_next = work_rdata;
                key_next  = {prev_reg, work_rdata};
                if (idx_reg == '0)
                begin
                    idx_next = LEN_W'(1);
                    if (LEN_W'(1) < wlen_reg)
                    begin
                        state_next = S_CNT_RD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCN_RD;
                    end
                end
                else
                begin
                    state_next = S_CNT_WR;
                end
            end

            S_CNT_WR:
            begin
                pair_we    = 1'b1;
                pair_wdata = pair_rdata + CNT_W'(1);
                idx_next   = idx_reg + LEN_W'(1);
                if ((idx_reg + LEN_W'(1)) >= wlen_reg)
                begin
                    idx_next   = '0;
                    state_next = S_SCN_RD;
                end
                else
                begin
                    state_next = S_CNT_RD;
                end
            end

            // find the greatest count, lowest key on ties, and zero as we go
            S_SCN_RD:
            begin
                state_next = S_SCN_KEY;
            end

            S_SCN_KEY:
            begin
                prev_next = work_rdata;
                key_next  = {prev_reg, work_rdata};
                if (idx_reg == '0)
                begin
                    idx_next   = LEN_W'(1);
                    state_next = (LEN_W'(1) < wlen_reg) ? S_SCN_RD : S_DECIDE;
                end
                else
                begin
                    state_next = S_SCN_CMP;
                end
            end

            S_SCN_CMP:
            begin
                pair_we  = 1'b1;
                idx_next = idx_reg + LEN_W'(1);
                if (pair_rdata > best_cnt_reg ||
                    (pair_rdata == best_cnt_reg && pair_rdata != '0 &&
                     key_reg < best_key_reg))
                begin
                    best_cnt_next = pair_rdata;
                    best_key_next = key_reg;
                end
                state_next = ((idx_reg + LEN_W'(1)) < wlen_reg) ? S_SCN_RD : S_DECIDE;
            end

            // stop or fetch the next free token
            S_DECIDE:
            begin
                if (best_cnt_reg == '0 || best_cnt_reg < thr)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    tok_ctl.seek      = 1'b1;
                    tok_ctl.seek_from = from_reg;
                    state_next        = S_SEEK;
                end
            end

            S_SEEK:
            begin
                if (tok_st.found)
                begin
                    dict_we     = 1'b1;
                    tok_next    = tok_st.token;
                    from_next   = tok_st.token + 8'd1;
                    idx_next    = '0;
                    dst_next    = '0;
                    pend_v_next = 1'b0;
                    state_next  = S_SUB_RD;
                end
            end

            // replace the pair left to right, in place
            S_SUB_RD:
            begin
                state_next = S_SUB_DATA;
            end

            S_SUB_DATA:
            begin
                if (pend_v_reg && pend_reg == best_key_reg[15:8] &&
                    work_rdata == best_key_reg[7:0])
                begin
                    work_we     = 1'b1;
                    work_wdata  = tok_reg;
                    dst_next    = dst_reg + LEN_W'(1);
                    pend_v_next = 1'b0;
                end
                else if (pend_v_reg)
                begin
                    work_we   = 1'b1;
                    dst_next  = dst_reg + LEN_W'(1);
                    pend_next = work_rdata;
                end
                else
                begin
                    pend_next   = work_rdata;
                    pend_v_next = 1'b1;
                end
                idx_next   = idx_reg + LEN_W'(1);
                state_next = ((idx_reg + LEN_W'(1)) < wlen_reg) ? S_SUB_RD : S_SUB_FLUSH;
            end

            S_SUB_FLUSH:
            begin
                work_we    = pend_v_reg;
                wlen_next  = wlen_fin;
                entry_next = entry_reg + 8'd1;
                state_next = S_LOOP;
            end

            // publish the block and the status item
            S_FINISH:
            begin
                if (entry_reg == '0)
                begin
                    base_next = '0;
                    blen_next = wlen_reg;
                end
                else
                begin
                    base_next   = base_calc;
                    blen_next   = base_calc + wlen_reg;
                    status_next = ST_APPLIED;
                end
                ovalid_next  = 1'b1;
                okind_next   = KIND_STATUS;
                ostatus_next = (entry_reg == '0) ? status_reg : ST_APPLIED;
                oblen_next   = (entry_reg == '0) ? wlen_reg : base_calc + wlen_reg;
                oentry_next  = entry_reg;
                obyte_next   = '0;
                olast_next   = 1'b0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            stored_reg   <= '0;
            blen_reg     <= '0;
            base_reg     <= '0;
            status_reg   <= ST_APPLIED;
            rp_reg       <= '0;
            sub_reg      <= '0;
            didx_reg     <= '0;
            entry_reg    <= '0;
            open_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            min_pair_reg <= RST_MIN_PAIR;
            min_len_reg  <= RST_MIN_LEN;
            max_ent_reg  <= RST_MAX_ENTRY;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            stored_reg   <= stored_next;
            blen_reg     <= blen_next;
            base_reg     <= base_next;
            status_reg   <= status_next;
            rp_reg       <= rp_next;
            sub_reg      <= sub_next;
            didx_reg     <= didx_next;
            entry_reg    <= entry_next;
            open_reg     <= open_next;
            ovf_reg      <= ovf_next;
            min_pair_reg <= min_pair_next;
            min_len_reg  <= min_len_next;
            max_ent_reg  <= max_ent_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        idx_reg      <= idx_next;
        dst_reg      <= dst_next;
        prev_reg     <= prev_next;
        key_reg      <= key_next;
        best_cnt_reg <= best_cnt_next;
        best_key_reg <= best_key_next;
        pend_reg     <= pend_next;
        pend_v_reg   <= pend_v_next;
        tok_reg      <= tok_next;
        from_reg     <= from_next;
        limit_reg    <= limit_next;
        wlen_reg     <= wlen_next;
        okind_reg    <= okind_next;
        ostatus_reg  <= ostatus_next;
        oblen_reg    <= oblen_next;
        oentry_reg   <= oentry_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
    end

    // response channel
    assign response.valid        = ovalid_reg;
    assign response.kind         = okind_reg;
    assign response.status       = ostatus_reg;
    assign response.block_length = oblen_reg;
    assign response.entry_count  = oentry_reg;
    assign response.out_byte     = obyte_reg;
    assign response.out_last     = olast_reg;

endmodule

// ===== rtl/core/bpde_ram.sv =====
// ----------------------------------------------------------------------------
// bpde_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bpde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/bpde_token_scan.sv =====
// ----------------------------------------------------------------------------
// bpde_token_scan
// seen-value map, free value count and a one-bit-per-cycle free token search
// ----------------------------------------------------------------------------
module bpde_token_scan
    import bpde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tok_ctl_t ctl,
    output tok_st_t  st
);

    logic [255:0]      seen_reg, seen_next;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [7:0]        ptr_reg, ptr_next;
    logic              busy_reg, busy_next;
    logic              found_reg, found_next;

    // map update and search step
    always_comb
    begin
        seen_next  = seen_reg;
        free_next  = free_reg;
        ptr_next   = ptr_reg;
        busy_next  = busy_reg;
        found_next = found_reg;
        if (ctl.clear)
        begin
            seen_next = '0;
            free_next = FREE_W'(256);
        end
        if (ctl.mark && !seen_next[ctl.mark_value])
        begin
            seen_next[ctl.mark_value] = 1'b1;
            free_next = free_next - FREE_W'(1);
        end
        if (ctl.seek)
        begin
            ptr_next   = ctl.seek_from;
            busy_next  = 1'b1;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!seen_reg[ptr_reg])
            begin
                busy_next  = 1'b0;
                found_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            free_reg  <= FREE_W'(256);
            ptr_reg   <= '0;
            busy_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            free_reg  <= free_next;
            ptr_reg   <= ptr_next;
            busy_reg  <= busy_next;
            found_reg <= found_next;
        end
    end

    assign st.found      = found_reg;
    assign st.token      = ptr_reg;
    assign st.free_count = free_reg;

endmodule

// ===== rtl/core/bpde_checker.sv =====
// ----------------------------------------------------------------------------
// bpde_checker
// port level checks of the byte pair dictionary encoder, bound to the core
// ----------------------------------------------------------------------------
`include "byte_pair_dictionary_encoder_core_defines.svh"

module bpde_checker
    import bpde_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rq_valid,
    input logic       rq_ready,
    input logic       rq_command,
    input logic       rs_valid,
    input logic       rs_ready,
    input logic       rs_kind,
    input logic [2:0] rs_status,
    input logic [7:0] rs_entry_count
);

    // a waiting response item stays until taken
    `BPDE_ASSERT_NEXT(a_rsp_hold, rs_valid && !rs_ready, rs_valid, "response item dropped")

    // no new item is taken while a response waits
    `BPDE_ASSERT_NOW(a_no_accept_full, rs_valid, !rq_ready, "request ready with response full")

    // an accepted read is not answered, and request is not ready, while in S_RD_ADDR
    `BPDE_ASSERT_NEXT(a_read_gap, rq_valid && rq_ready && rq_command == CMD_READ,
        !rs_valid && !rq_ready, "read answered or request ready too early")

    // a pass-through status reports no dictionary entries
    `BPDE_ASSERT_NOW(a_pass_entries, rs_valid && rs_kind == KIND_STATUS &&
        rs_status != ST_APPLIED, rs_entry_count == 8'd0, "entries on pass-through")

endmodule

bind byte_pair_dictionary_encoder_core bpde_checker u_bpde_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rq_valid       (request.valid),
    .rq_ready       (request.ready),
    .rq_command     (request.command),
    .rs_valid       (response.valid),
    .rs_ready       (response.ready),
    .rs_kind        (response.kind),
    .rs_status      (response.status),
    .rs_entry_count (response.entry_count)
);
